/* sv/assert_macros.svh */
// Assertion helpers for the RTL; included by pfre_datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/pfre_pkg.sv */
package pfre_pkg;

  typedef enum logic [1:0] {
    CMD_PIXEL   = 2'd0,
    CMD_REFRESH = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_REFRESH = 2'd1,
    MODE_CLEAR   = 2'd2
  } mode_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WORK = 1'b1
  } ctrl_state_e;

  localparam logic CFG_FLIPPED    = 1'b0;
  localparam logic CFG_DIRTY_ONLY = 1'b1;

  localparam logic [7:0] PAGE_CMD     = 8'hB0;
  localparam logic [7:0] COL_HIGH_CMD = 8'h10;
  localparam logic [7:0] FLIP_OFFSET  = 8'h04;
  localparam int         HEADER_BYTES = 3;

  typedef struct packed {
    logic capture;
    logic complete;
  } dp_cmd_t;

  typedef struct packed {
    logic can_accept;
    logic out_full;
  } dp_status_t;

endpackage

/* sv/pfre_ctrl.sv */
module pfre_ctrl
  import pfre_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output logic       in_ready_o,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o.capture  = 1'b0;
    cmd_o.complete = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = status_i.can_accept;
        if (in_valid_i && status_i.can_accept) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_WORK;
        end
      end
      ST_WORK: begin
        if (!status_i.out_full || out_ready_i) begin
          cmd_o.complete = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/pfre_datapath.sv */
`include "assert_macros.svh"

module pfre_datapath
  import pfre_pkg::*;
#(
  parameter int WIDTH         = 128,
  parameter int HEIGHT        = 64,
  parameter int BLANK_COLUMNS = 132
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    dp_cmd_i,
  output dp_status_t status_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic       cfg_data_i,
  input  logic [1:0] cmd_i,
  input  logic [7:0] pos_x_i,
  input  logic [7:0] pos_y_i,
  input  logic       colour_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       byte_valid_o,
  output logic       is_data_o,
  output logic [7:0] out_byte_o,
  output logic       done_res_o,
  output logic       busy_res_o,
  output logic       rejected_o
);

  localparam int PAGES  = (HEIGHT + 7) / 8;
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int DEPTH  = WIDTH * PAGES;
  localparam int AW     = $clog2(DEPTH);
  localparam int POS_W  = $clog2(BLANK_COLUMNS + HEADER_BYTES + 1);
  localparam logic [POS_W-1:0] LAST_DATA  = POS_W'(HEADER_BYTES + WIDTH - 1);
  localparam logic [POS_W-1:0] LAST_BLANK = POS_W'(HEADER_BYTES + BLANK_COLUMNS - 1);

  function automatic logic [PAGE_W:0] pick_page(input logic [PAGE_W:0] from,
                                                input logic [PAGES-1:0] marks,
                                                input logic use_marks);
    logic [PAGE_W:0] res;
    res = '0;
    for (int p = PAGES - 1; p >= 0; p--) begin
      if (((PAGE_W + 1)'(p) >= from) && (!use_marks || marks[p])) begin
        res = {1'b1, PAGE_W'(p)};
      end
    end
    return res;
  endfunction

  logic [7:0] mem [DEPTH];

  mode_e             mode_q, mode_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [PAGES-1:0]  dirty_q, dirty_d;
  logic              flipped_q, dirty_only_q;
  logic              sweep_q;
  logic [AW-1:0]     sweep_addr_q;
  logic              out_valid_q;

  cmd_e              icmd_q;
  logic              icol_q;
  logic              in_range_q;
  logic [AW-1:0]     addr_q;
  logic [2:0]        bit_q;
  logic [PAGE_W-1:0] pix_page_q;
  logic [7:0]        rdata_q;

  logic              byte_valid_q, is_data_q, done_q, busy_q, rejected_q;
  logic [7:0]        out_byte_q;

  logic [7:0]        xi, yi;
  logic              pix_in_range;
  logic [AW-1:0]     pix_addr, ref_addr, raddr;
  logic [PAGE_W:0]   nxt_pick, start_pick;
  logic              refresh;
  logic              pix_wr, sweep_start;
  logic [7:0]        bit_mask, wdata;
  logic              r_byte_valid, r_is_data, r_done, r_busy, r_rejected;
  logic [7:0]        r_byte;

  assign xi = pos_x_i - 8'd1;
  assign yi = pos_y_i - 8'd1;
  assign pix_in_range = (pos_x_i != 8'd0) && (int'(pos_x_i) <= WIDTH) &&
                        (pos_y_i != 8'd0) && (int'(pos_y_i) <= HEIGHT);
  assign pix_addr = AW'(int'(yi[7:3]) * WIDTH + int'(xi));
  assign ref_addr = AW'(int'(page_q) * WIDTH + int'(pos_q) - HEADER_BYTES);
  assign raddr    = (mode_q == MODE_IDLE) ? pix_addr : ref_addr;

  assign refresh    = (mode_q == MODE_REFRESH);
  assign nxt_pick   = pick_page({1'b0, page_q} + (PAGE_W + 1)'(1), dirty_q,
                                refresh && dirty_only_q);
  assign start_pick = pick_page('0, dirty_q, dirty_only_q);

  assign bit_mask = 8'd1 << bit_q;
  assign wdata    = icol_q ? (rdata_q | bit_mask) : (rdata_q & ~bit_mask);

  assign status_o.can_accept = !sweep_q || (mode_q == MODE_CLEAR);
  assign status_o.out_full   = out_valid_q;
  assign cfg_ready_o         = 1'b1;

  always_comb begin
    mode_d       = mode_q;
    page_d       = page_q;
    pos_d        = pos_q;
    dirty_d      = dirty_q;
    pix_wr       = 1'b0;
    sweep_start  = 1'b0;
    r_byte_valid = 1'b0;
    r_is_data    = 1'b0;
    r_byte       = 8'd0;
    r_done       = 1'b0;
    r_busy       = 1'b0;
    r_rejected   = 1'b0;
    if (dp_cmd_i.complete) begin
      case (mode_q)
        MODE_REFRESH, MODE_CLEAR: begin
          if (icmd_q != CMD_TICK) begin
            r_rejected = 1'b1;
            r_busy     = 1'b1;
          end else begin
            r_byte_valid = 1'b1;
            r_is_data    = (pos_q >= POS_W'(HEADER_BYTES));
            if (pos_q == POS_W'(0)) begin
              r_byte = PAGE_CMD | {5'd0, 3'(page_q)};
            end else if (pos_q == POS_W'(1)) begin
              r_byte = (refresh && flipped_q) ? FLIP_OFFSET : 8'd0;
            end else if (pos_q == POS_W'(2)) begin
              r_byte = COL_HIGH_CMD;
            end else if (refresh) begin
              r_byte = rdata_q;
            end
            if (pos_q == (refresh ? LAST_DATA : LAST_BLANK)) begin
              pos_d = '0;
              if (!nxt_pick[PAGE_W]) begin
                if (refresh) begin
                  dirty_d = '0;
                end
                mode_d = MODE_IDLE;
                page_d = '0;
                r_done = 1'b1;
              end else begin
                page_d = nxt_pick[PAGE_W-1:0];
                r_busy = 1'b1;
              end
            end else begin
              pos_d  = pos_q + POS_W'(1);
              r_busy = 1'b1;
            end
          end
        end
        MODE_IDLE: begin
          case (icmd_q)
            CMD_PIXEL: begin
              if (in_range_q) begin
                pix_wr  = 1'b1;
                dirty_d = dirty_q | (PAGES'(1) << pix_page_q);
              end
            end
            CMD_REFRESH: begin
              if (!start_pick[PAGE_W]) begin
                dirty_d = '0;
                r_done  = 1'b1;
              end else begin
                mode_d = MODE_REFRESH;
                page_d = start_pick[PAGE_W-1:0];
                pos_d  = '0;
                r_busy = 1'b1;
              end
            end
            CMD_CLEAR: begin
              sweep_start = 1'b1;
              mode_d      = MODE_CLEAR;
              page_d      = '0;
              pos_d       = '0;
              r_busy      = 1'b1;
            end
            default: begin
            end
          endcase
        end
        default: begin
          mode_d = MODE_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      page_q       <= '0;
      pos_q        <= '0;
      dirty_q      <= '0;
      flipped_q    <= 1'b0;
      dirty_only_q <= 1'b0;
      sweep_q      <= 1'b1;
      sweep_addr_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      page_q  <= page_d;
      pos_q   <= pos_d;
      dirty_q <= dirty_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_FLIPPED) begin
          flipped_q <= cfg_data_i;
        end else begin
          dirty_only_q <= cfg_data_i;
        end
      end
      if (sweep_q) begin
        sweep_addr_q <= sweep_addr_q + AW'(1);
        if (sweep_addr_q == AW'(DEPTH - 1)) begin
          sweep_q <= 1'b0;
        end
      end else if (sweep_start) begin
        sweep_q      <= 1'b1;
        sweep_addr_q <= '0;
      end
      if (dp_cmd_i.complete) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.capture) begin
      icmd_q     <= cmd_e'(cmd_i);
      icol_q     <= colour_i;
      in_range_q <= pix_in_range;
      addr_q     <= pix_addr;
      bit_q      <= yi[2:0];
      pix_page_q <= PAGE_W'(yi[7:3]);
    end
    if (dp_cmd_i.complete) begin
      byte_valid_q <= r_byte_valid;
      is_data_q    <= r_is_data;
      out_byte_q   <= r_byte;
      done_q       <= r_done;
      busy_q       <= r_busy;
      rejected_q   <= r_rejected;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sweep_q) begin
      mem[sweep_addr_q] <= 8'd0;
    end else if (pix_wr) begin
      mem[addr_q] <= wdata;
    end
    if (dp_cmd_i.capture) begin
      rdata_q <= mem[raddr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign byte_valid_o = byte_valid_q;
  assign is_data_o    = is_data_q;
  assign out_byte_o   = out_byte_q;
  assign done_res_o   = done_q;
  assign busy_res_o   = busy_q;
  assign rejected_o   = rejected_q;

  `ASSERT_IMPLIES(a_sweep_excludes_pixel_write, clk_i, rst_ni, sweep_q, !pix_wr)
  `ASSERT_IMPLIES(a_sweep_only_idle_or_clear, clk_i, rst_ni, sweep_q, mode_q != MODE_REFRESH)
  `ASSERT_IMPLIES(a_load_into_free_slot, clk_i, rst_ni, dp_cmd_i.complete, !out_valid_q || out_ready_i)
  `ASSERT_IMPLIES(a_refresh_pos_bound, clk_i, rst_ni, mode_q == MODE_REFRESH, pos_q <= LAST_DATA)
  `ASSERT_NEXT(a_one_item_in_flight, clk_i, rst_ni, dp_cmd_i.capture, !dp_cmd_i.capture)

endmodule

/* sv/page_framebuffer_refresh_engine_unit.sv */
// Page frame buffer with a refresh engine for a one-bit monochrome panel.
// Input words carry a command (pixel write, start refresh, start clear, tick)
// with pixel coordinates and colour; every accepted input word gives exactly
// one output word on the result channel. Each tick during a refresh or clear
// returns one display byte with its register select flag.
// Configuration (flip offset, dirty-only refresh) is written through the cfg
// channel, which is always ready.
// An input word is captured at its accepting edge; its result is loaded into the
// output register once that register is free, and no further input word is taken
// until that load, so the block handles one input word at a time.
// This is set by the synchronous read of the frame store, whose data is used or
// written back after the capture.
// After reset the frame store is swept to zero, one byte a cycle over all
// WIDTH * ceil(HEIGHT / 8) bytes (1024 with the default sizes), while no input
// word is accepted. A clear runs the same sweep behind the blank page stream.
// When the receiver stalls, the result waits in the output register; one further
// input word may still be accepted and is held until that register is free, and
// no input word is accepted after it until then.
module page_framebuffer_refresh_engine_unit
  import pfre_pkg::*;
#(
  parameter int WIDTH         = 128,
  parameter int HEIGHT        = 64,
  parameter int BLANK_COLUMNS = 132
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] pos_x_i,
  input  logic [7:0] pos_y_i,
  input  logic       colour_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       byte_valid_o,
  output logic       is_data_o,
  output logic [7:0] out_byte_o,
  output logic       done_res_o,
  output logic       busy_res_o,
  output logic       rejected_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  pfre_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .in_ready_o  (in_ready_o),
    .cmd_o       (dp_cmd)
  );

  pfre_datapath #(
    .WIDTH         (WIDTH),
    .HEIGHT        (HEIGHT),
    .BLANK_COLUMNS (BLANK_COLUMNS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dp_cmd_i     (dp_cmd),
    .status_o     (dp_status),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .colour_i     (colour_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .byte_valid_o (byte_valid_o),
    .is_data_o    (is_data_o),
    .out_byte_o   (out_byte_o),
    .done_res_o   (done_res_o),
    .busy_res_o   (busy_res_o),
    .rejected_o   (rejected_o)
  );

endmodule
